FILE: src/pcbp_pkg.sv
// Shared types and constants for the prefix code bit packer.
package pcbp_pkg;

  localparam int PCBP_MAX_CODE_LEN = 24;
  localparam int PCBP_QUEUE_DEPTH  = 4;
  localparam int BYTE_BITS         = 8;
  localparam int SYM_COUNT         = 256;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_ENCODE = 2'd1;
  localparam logic [1:0] OP_FLUSH  = 2'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  symbol;
    logic [23:0] code_word;
    logic [4:0]  code_length;
  } pcbp_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_header;
    logic       last;
  } pcbp_out_t;

  // work handed from the front end to the packing back end
  typedef struct packed {
    logic        flush;
    logic [23:0] code;
    logic [4:0]  len;
  } pcbp_job_t;

endpackage

FILE: src/pcbp_front.sv
// Front end: request intake, code table storage and lookup.
module pcbp_front import pcbp_pkg::*; #(
  parameter int MAX_CODE_LEN = PCBP_MAX_CODE_LEN
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  pcbp_in_t  in_data,
  output logic      q_push,
  output pcbp_job_t q_job,
  input  logic      q_full
);

  localparam int LEN_MAX = (MAX_CODE_LEN > 31) ? 31 : MAX_CODE_LEN;

  logic [23:0]          code_mem [SYM_COUNT];
  logic [4:0]           len_mem  [SYM_COUNT];
  logic [SYM_COUNT-1:0] ent_vld_r, ent_vld_nxt;

  logic        s1_vld_r, s1_vld_nxt;
  logic        s1_flush_r;
  logic [23:0] rd_code_r;
  logic [4:0]  rd_len_r;
  logic        rd_hit_r;

  logic        accept;
  logic [4:0]  len_sat;
  logic [23:0] code_mask;

  assign in_stall = s1_vld_r && q_full;
  assign accept   = in_valid && !in_stall;

  assign len_sat   = (in_data.code_length > 5'(LEN_MAX)) ? 5'(LEN_MAX) : in_data.code_length;
  assign code_mask = (len_sat >= 5'd24) ? '1 : ((24'd1 << len_sat) - 24'd1);

  always_ff @(posedge clk) begin
    if (accept && in_data.operation == OP_LOAD) begin
      code_mem[in_data.symbol] <= in_data.code_word & code_mask;
      len_mem[in_data.symbol]  <= len_sat;
    end
    if (accept) begin
      rd_code_r  <= code_mem[in_data.symbol];
      rd_len_r   <= len_mem[in_data.symbol];
      rd_hit_r   <= ent_vld_r[in_data.symbol];
      s1_flush_r <= (in_data.operation == OP_FLUSH);
    end
  end

  always_comb begin
    ent_vld_nxt = ent_vld_r;
    if (accept && in_data.operation == OP_LOAD) ent_vld_nxt[in_data.symbol] = 1'b1;
    if (accept) begin
      s1_vld_nxt = (in_data.operation == OP_ENCODE) || (in_data.operation == OP_FLUSH);
    end else if (!q_full) begin
      s1_vld_nxt = 1'b0;
    end else begin
      s1_vld_nxt = s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r <= '0;
      s1_vld_r  <= 1'b0;
    end else begin
      ent_vld_r <= ent_vld_nxt;
      s1_vld_r  <= s1_vld_nxt;
    end
  end

  // entries never loaded read as absent
  assign q_job.flush = s1_flush_r;
  assign q_job.code  = rd_code_r;
  assign q_job.len   = rd_hit_r ? rd_len_r : 5'd0;
  assign q_push      = s1_vld_r && !q_full && (s1_flush_r || q_job.len != 5'd0);

endmodule

FILE: src/pcbp_queue.sv
// Small job queue between the front end and the back end.
module pcbp_queue import pcbp_pkg::*; #(
  parameter int DEPTH = PCBP_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  pcbp_job_t push_job,
  output logic      full,
  input  logic      pop,
  output pcbp_job_t pop_job,
  output logic      nonempty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  pcbp_job_t        slot [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign nonempty = (cnt_r != '0);
  assign pop_job  = slot[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr_r] <= push_job;
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    if (pop)  rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    if (push && !pop)      cnt_nxt = cnt_r + CNT_W'(1);
    else if (pop && !push) cnt_nxt = cnt_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

FILE: src/pcbp_back.sv
// Back end: bit accumulator, byte emission, header and flush handling.
module pcbp_back import pcbp_pkg::*; #(
  parameter int MAX_CODE_LEN = PCBP_MAX_CODE_LEN
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_nonempty,
  input  pcbp_job_t  q_job,
  output logic       q_pop,
  input  logic       cfg_wr_en,
  input  logic [3:0] cfg_wr_data,
  output logic       out_valid,
  input  logic       out_stall,
  output pcbp_out_t  out_data
);

  localparam int LEN_MAX = (MAX_CODE_LEN > 31) ? 31 : MAX_CODE_LEN;
  localparam int ACC_W   = LEN_MAX + BYTE_BITS - 1;
  localparam int CNT_W   = $clog2(ACC_W + 1);

  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, sh;
  logic             hdr_r, hdr_nxt;
  logic             fl_r, fl_nxt;
  logic [3:0]       pad_r;
  logic             out_vld_r;
  pcbp_out_t        out_r, ob;
  logic             emit, emit_ok, busy;
  logic [ACC_W-1:0] low_mask;

  assign busy     = (cnt_r >= CNT_W'(BYTE_BITS)) || fl_r;
  assign q_pop    = !busy && q_nonempty;
  assign emit_ok  = !out_vld_r || !out_stall;
  assign sh       = cnt_r - CNT_W'(BYTE_BITS);
  // bits above the count may hold stale data
  assign low_mask = (ACC_W'(1) << cnt_r) - ACC_W'(1);

  always_comb begin
    acc_nxt = acc_r;
    cnt_nxt = cnt_r;
    hdr_nxt = hdr_r;
    fl_nxt  = fl_r;
    emit    = 1'b0;
    ob      = '0;
    if (q_pop) begin
      if (q_job.flush) begin
        fl_nxt = 1'b1;
      end else begin
        acc_nxt = (acc_r << q_job.len) | ACC_W'(q_job.code);
        cnt_nxt = cnt_r + CNT_W'(q_job.len);
      end
    end else if (cnt_r >= CNT_W'(BYTE_BITS)) begin
      if (emit_ok) begin
        emit = 1'b1;
        if (!hdr_r) begin
          ob.out_byte  = 8'(pad_r);
          ob.is_header = 1'b1;
          hdr_nxt      = 1'b1;
        end else begin
          ob.out_byte = 8'(acc_r >> sh);
          ob.last     = (sh < CNT_W'(BYTE_BITS));
          cnt_nxt     = sh;
        end
      end
    end else if (fl_r) begin
      if (!hdr_r) begin
        if (emit_ok) begin
          emit         = 1'b1;
          ob.out_byte  = 8'(pad_r);
          ob.is_header = 1'b1;
          ob.last      = (cnt_r == '0);
          hdr_nxt      = 1'b1;
        end
      end else if (cnt_r != '0) begin
        if (emit_ok) begin
          emit        = 1'b1;
          ob.out_byte = 8'(acc_r & low_mask);
          ob.last     = 1'b1;
          acc_nxt     = '0;
          cnt_nxt     = '0;
          hdr_nxt     = 1'b0;
          fl_nxt      = 1'b0;
        end
      end else begin
        acc_nxt = '0;
        hdr_nxt = 1'b0;
        fl_nxt  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r     <= '0;
      cnt_r     <= '0;
      hdr_r     <= 1'b0;
      fl_r      <= 1'b0;
      pad_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      acc_r <= acc_nxt;
      cnt_r <= cnt_nxt;
      hdr_r <= hdr_nxt;
      fl_r  <= fl_nxt;
      if (cfg_wr_en) pad_r <= cfg_wr_data;
      if (emit)            out_vld_r <= 1'b1;
      else if (!out_stall) out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) out_r <= ob;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

FILE: src/prefix_code_bit_packer_top.sv
// Prefix code bit packer: a table lookup front end feeds a byte packing back end
// through a short queue. An item is accepted every cycle while the queue has room.
// In the back end an encode merges its code into the accumulator and then emits each
// full output byte, with a header byte first in a message; a flush emits the header if
// none went yet, then any remaining bits, and clears. The back end takes no new job
// while it holds a full byte or a pending flush. The code table is written and read at
// the request edge; length entries start absent through per-entry valid flops, so no
// clearing pass follows reset.
module prefix_code_bit_packer_top import pcbp_pkg::*; #(
  parameter int MAX_CODE_LEN = PCBP_MAX_CODE_LEN,
  parameter int QUEUE_DEPTH  = PCBP_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  pcbp_in_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output pcbp_out_t  out_data,
  input  logic       cfg_wr_en,
  input  logic [3:0] cfg_wr_data
);

  logic      q_push, q_full, q_pop, q_nonempty;
  pcbp_job_t push_job, pop_job;

  pcbp_front #(.MAX_CODE_LEN(MAX_CODE_LEN)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_push   (q_push),
    .q_job    (push_job),
    .q_full   (q_full)
  );

  pcbp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .pop_job  (pop_job),
    .nonempty (q_nonempty)
  );

  pcbp_back #(.MAX_CODE_LEN(MAX_CODE_LEN)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_nonempty  (q_nonempty),
    .q_job       (pop_job),
    .q_pop       (q_pop),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule

FILE: src/pcbp_checker.sv
// Port-level checks for the prefix code bit packer, bound to the top level.
module pcbp_checker import pcbp_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input pcbp_out_t out_data
);

  // reset leaves nothing in flight on either side
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid && !in_stall)
    else $error("pipeline not idle after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output request changed");

  // header carries only the 4-bit pad count
  a_hdr_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_header |-> out_data.out_byte[7:4] == 4'd0)
    else $error("header byte out of range");

endmodule

bind prefix_code_bit_packer_top pcbp_checker u_chk (.*);

FILE: verif/tb_prefix_code_bit_packer_top.sv
// Testbench for prefix_code_bit_packer_top: directed table, random requests, scoreboard.
`timescale 1ns / 1ps

module tb_prefix_code_bit_packer_top;
  import pcbp_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int         MAX_LEN   = PCBP_MAX_CODE_LEN;
  localparam int         SETTLE    = 30;
  localparam int         PHASE_REQS = 140;
  localparam pcbp_out_t  NO_RES    = '0;

  typedef struct {
    pcbp_in_t              req;
    bit                    typed;
    int                    n_res;
    pcbp_out_t [3:0]       res;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  pcbp_in_t   in_data;
  logic       out_valid;
  logic       out_stall;
  pcbp_out_t  out_data;
  logic       cfg_wr_en;
  logic [3:0] cfg_wr_data;

  prefix_code_bit_packer_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  // packer model state
  logic [23:0] code_tbl [SYM_COUNT];
  logic [4:0]  len_tbl  [SYM_COUNT];
  bit          sym_loaded [SYM_COUNT];
  logic [7:0]  loaded_syms [$];
  logic [63:0] acc_bits;
  int          acc_cnt;
  bit          hdr_done;
  logic [3:0]  pad_reg;

  pcbp_out_t   step_bytes [$];
  pcbp_out_t   expected_bytes [$];
  dir_row_t    dir_tab [$];

  int send_idle_pct = 10;
  int recv_idle_pct = 55;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;

  int mismatches = 0;
  int bytes_checked = 0;
  int headers_seen = 0;
  int n_loads = 0;
  int n_encodes = 0;
  int n_flushes = 0;

  function automatic pcbp_out_t mk(input logic [7:0] b, input logic h, input logic l);
    pcbp_out_t r;
    r.out_byte  = b;
    r.is_header = h;
    r.last      = l;
    return r;
  endfunction

  function automatic pcbp_in_t req(input logic [1:0] op, input logic [7:0] sym,
                                   input logic [23:0] word, input logic [4:0] len);
    pcbp_in_t r;
    r.operation   = op;
    r.symbol      = sym;
    r.code_word   = word;
    r.code_length = len;
    return r;
  endfunction

  function automatic void add_row(input pcbp_in_t r, input bit typed, input int n_res,
                                  input pcbp_out_t [3:0] res);
    dir_row_t row;
    row.req   = r;
    row.typed = typed;
    row.n_res = n_res;
    row.res   = res;
    dir_tab.insert(dir_tab.size(), row);
  endfunction

  // Applies one accepted request to the model; the bytes it causes land in step_bytes.
  function automatic void predict_packed_bytes(input pcbp_in_t r);
    logic [4:0]  cl;
    logic [63:0] code;
    int          sh;
    pcbp_out_t   tail;
    step_bytes.delete();
    case (r.operation)
      OP_LOAD: begin
        code_tbl[r.symbol] = r.code_word;
        len_tbl[r.symbol]  = (r.code_length > MAX_LEN) ? 5'(MAX_LEN) : r.code_length;
        if (!sym_loaded[r.symbol]) begin
          sym_loaded[r.symbol] = 1'b1;
          loaded_syms.insert(loaded_syms.size(), r.symbol);
        end
        n_loads++;
      end
      OP_ENCODE: begin
        cl = len_tbl[r.symbol];
        n_encodes++;
        if (cl != 0) begin
          code     = 64'(code_tbl[r.symbol]) & ((64'h1 << cl) - 64'h1);
          acc_bits = (acc_bits << cl) | code;
          acc_cnt += int'(cl);
          while (acc_cnt >= BYTE_BITS) begin
            sh = acc_cnt - BYTE_BITS;
            if (!hdr_done) begin
              step_bytes.insert(step_bytes.size(), mk(8'(pad_reg), 1'b1, 1'b0));
              hdr_done = 1'b1;
            end
            step_bytes.insert(step_bytes.size(), mk(8'(acc_bits >> sh), 1'b0, 1'b0));
            acc_cnt   = sh;
            acc_bits &= (64'h1 << sh) - 64'h1;
          end
        end
      end
      OP_FLUSH: begin
        n_flushes++;
        if (!hdr_done)
          step_bytes.insert(step_bytes.size(), mk(8'(pad_reg), 1'b1, 1'b0));
        if (acc_cnt != 0)
          step_bytes.insert(step_bytes.size(), mk(acc_bits[7:0], 1'b0, 1'b0));
        acc_bits = '0;
        acc_cnt  = 0;
        hdr_done = 1'b0;
      end
      default: ;
    endcase
    if (step_bytes.size() > 0) begin
      tail      = step_bytes[step_bytes.size() - 1];
      tail.last = 1'b1;
      step_bytes[step_bytes.size() - 1] = tail;
    end
  endfunction

  function automatic pcbp_in_t rand_request();
    int unsigned pick;
    logic [4:0]  len;
    pick = $urandom_range(99);
    if (loaded_syms.size() == 0 || pick < 18) begin
      case ($urandom_range(9))
        0:       len = 5'd0;
        1:       len = 5'($urandom_range(31, 25));
        2, 3, 4: len = 5'($urandom_range(8, 1));
        default: len = 5'($urandom_range(24, 9));
      endcase
      return req(OP_LOAD, 8'($urandom_range(255)), 24'($urandom), len);
    end
    if (pick < 87)
      return req(OP_ENCODE, loaded_syms[$urandom_range(loaded_syms.size() - 1)],
                 24'($urandom), 5'($urandom));
    if (pick < 97)
      return req(OP_FLUSH, 8'($urandom), 24'($urandom), 5'($urandom));
    return req(OP_UNUSED, 8'($urandom), 24'($urandom), 5'($urandom));
  endfunction

  // Starts and ends at a falling edge; predicts at the accepting edge.
  task automatic offer(input pcbp_in_t r, input bit typed, input int n_res,
                       input pcbp_out_t [3:0] res);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (in_stall);
    predict_packed_bytes(r);
    if (typed) begin
      for (int i = 0; i < n_res; i++) expected_bytes.insert(expected_bytes.size(), res[i]);
    end else begin
      foreach (step_bytes[i]) expected_bytes.insert(expected_bytes.size(), step_bytes[i]);
    end
    @(negedge clk);
  endtask

  // Loads give no bytes, so the task also waits out the SETTLE period once the expected queue is empty.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_pad(input logic [3:0] v);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    pad_reg = v;
  endtask

  // receiver: random stall, plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = 400;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic report_mismatch(input pcbp_out_t exp_r, input pcbp_out_t got, input bit none);
    mismatches++;
    if (mismatches <= 10) begin
      if (none)
        $display("%0t: unexpected byte %02h hdr=%0b last=%0b", $realtime,
                 got.out_byte, got.is_header, got.last);
      else
        $display("%0t: exp byte %02h hdr=%0b last=%0b, got byte %02h hdr=%0b last=%0b",
                 $realtime, exp_r.out_byte, exp_r.is_header, exp_r.last,
                 got.out_byte, got.is_header, got.last);
    end
  endtask

  always @(posedge clk) begin
    pcbp_out_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      bytes_checked++;
      if (out_data.is_header === 1'b1) headers_seen++;
      if (expected_bytes.size() == 0) begin
        report_mismatch(NO_RES, out_data, 1'b1);
      end else begin
        exp_r = expected_bytes.pop_front();
        if (out_data.out_byte !== exp_r.out_byte || out_data.is_header !== exp_r.is_header ||
            out_data.last !== exp_r.last)
          report_mismatch(exp_r, out_data, 1'b0);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    pcbp_in_t    r;
    int          sent;
    logic [3:0]  phase_pad [3];
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    out_stall   = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    acc_bits    = '0;
    acc_cnt     = 0;
    hdr_done    = 1'b0;
    pad_reg     = '0;
    foreach (len_tbl[i]) begin
      len_tbl[i]    = '0;
      code_tbl[i]   = '0;
      sym_loaded[i] = 1'b0;
    end
    phase_pad[0] = 4'd8;
    phase_pad[1] = 4'd15;
    phase_pad[2] = 4'($urandom_range(7, 1));

    // pad is zero here, so header bytes read 00
    add_row(req(OP_FLUSH, 8'h00, 24'h000000, 5'd0), 1'b1, 1,
            {NO_RES, NO_RES, NO_RES, mk(8'h00, 1'b1, 1'b1)});
    add_row(req(OP_LOAD, 8'h00, 24'hFFFFFF, 5'd31), 1'b1, 0, '0);
    add_row(req(OP_ENCODE, 8'h00, 24'h000000, 5'd0), 1'b1, 4,
            {mk(8'hFF, 1'b0, 1'b1), mk(8'hFF, 1'b0, 1'b0),
             mk(8'hFF, 1'b0, 1'b0), mk(8'h00, 1'b1, 1'b0)});
    add_row(req(OP_FLUSH, 8'hFF, 24'hFFFFFF, 5'd31), 1'b1, 0, '0);
    add_row(req(OP_LOAD, 8'hFF, 24'h000000, 5'd1), 1'b1, 0, '0);
    add_row(req(OP_LOAD, 8'h01, 24'hABCDEF, 5'd8), 1'b1, 0, '0);
    add_row(req(OP_ENCODE, 8'h01, 24'h000000, 5'd0), 1'b1, 2,
            {NO_RES, NO_RES, mk(8'hEF, 1'b0, 1'b1), mk(8'h00, 1'b1, 1'b0)});
    add_row(req(OP_ENCODE, 8'hFF, 24'h000000, 5'd0), 1'b0, 0, '0);
    // absent symbol: zero length
    add_row(req(OP_LOAD, 8'h02, 24'h5A5A5A, 5'd0), 1'b1, 0, '0);
    add_row(req(OP_ENCODE, 8'h02, 24'h000000, 5'd0), 1'b1, 0, '0);
    add_row(req(OP_FLUSH, 8'h00, 24'h000000, 5'd0), 1'b1, 1,
            {NO_RES, NO_RES, NO_RES, mk(8'h00, 1'b0, 1'b1)});
    add_row(req(OP_UNUSED, 8'hAA, 24'h555555, 5'd21), 1'b1, 0, '0);
    add_row(req(OP_LOAD, 8'h80, 24'h000005, 5'd3), 1'b0, 0, '0);
    add_row(req(OP_ENCODE, 8'h80, 24'h000000, 5'd0), 1'b0, 0, '0);
    add_row(req(OP_ENCODE, 8'h80, 24'h000000, 5'd0), 1'b0, 0, '0);
    add_row(req(OP_ENCODE, 8'h80, 24'h000000, 5'd0), 1'b0, 0, '0);
    add_row(req(OP_FLUSH, 8'h00, 24'h000000, 5'd0), 1'b0, 0, '0);
    add_row(req(OP_LOAD, 8'h7F, 24'h800001, 5'd24), 1'b0, 0, '0);
    add_row(req(OP_LOAD, 8'h55, 24'hFFFFFE, 5'd7), 1'b0, 0, '0);
    add_row(req(OP_ENCODE, 8'h55, 24'h000000, 5'd0), 1'b0, 0, '0);
    add_row(req(OP_ENCODE, 8'h7F, 24'h000000, 5'd0), 1'b0, 0, '0);
    add_row(req(OP_ENCODE, 8'h00, 24'h000000, 5'd0), 1'b0, 0, '0);
    add_row(req(OP_FLUSH, 8'h00, 24'h000000, 5'd0), 1'b0, 0, '0);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_pad(4'd0);
    foreach (dir_tab[i]) offer(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].n_res,
                               dir_tab[i].res);

    for (int ph = 0; ph < 3; ph++) begin
      write_pad(phase_pad[ph]);
      send_idle_pct = (ph == 0) ? 10 : (ph == 1) ? 55 : 0;
      recv_idle_pct = (ph == 0) ? 55 : (ph == 1) ? 10 : 0;
      sent = 0;
      while (sent < PHASE_REQS) begin
        if (ph == 1 && sent == 60) begin
          // sender pauses until the result side has fully drained
          in_valid <= 1'b0;
          while (expected_bytes.size() != 0) @(posedge clk);
          @(negedge clk);
        end
        if (ph == 2 && sent == 40) hold_req = 1'b1;
        r = rand_request();
        offer(r, 1'b0, 0, '0);
        if (r.operation != OP_UNUSED) sent++;
      end
    end

    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Run covered %0d loads, %0d encodes, %0d flushes under pads 0, 8, 15 and %0d",
             n_loads, n_encodes, n_flushes, phase_pad[2]);
    $display("%0d output bytes checked, %0d of them headers, %0d mismatching",
             bytes_checked, headers_seen, mismatches);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
